FILE: sv/mma_pkg.sv
// Shared types, constants and command codes for the matrix multiply-accumulate block.
package mma_pkg;

  // Built maximum matrix dimension
  localparam int MAX_DIM_DEF = 8;

  // Field widths fixed by the item formats
  localparam int DATA_W     = 64;
  localparam int HALF_W     = 32;
  localparam int IDX_FLD_W  = 3;
  localparam int SIZE_W     = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // matrix_size value after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // Register index, taken from the word address bit of paddr
  localparam logic REG_MATRIX_SIZE = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_LOAD_C  = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [IDX_FLD_W-1:0]     row;
    logic [IDX_FLD_W-1:0]     col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_FLD_W-1:0]     out_row;
    logic [IDX_FLD_W-1:0]     out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                     last;
  } out_item_t;

endpackage

FILE: sv/matrix_multiply_accumulate.sv
// Matrix multiply-accumulate top level: C = C + A*B over an n by n size in use.
// Load items (A, B or C element) give no result; busy stays low.
// A compute item keeps busy high over all n*n elements: each product step runs the fetch
// and three multiply states on one shared 32x32 multiplier (three partial products), and each
// element ends with a finish and an emit state, after which element (i,j) is registered out.
// Results are strobed for one cycle by out_valid; the receiver cannot stall them.
// Synchronous active-low reset idles the sequencer and sets matrix_size to 8; stores are not cleared.
module matrix_multiply_accumulate
  import mma_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_M0    = 7'b0000100,
    S_M1    = 7'b0001000,
    S_M2    = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  function automatic logic [ADDR_W-1:0] addr_of(input int unsigned r, input int unsigned c);
    return ADDR_W'(r * MAX_DIM + c);
  endfunction

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IDX_W-1:0]    n_last_r, n_last_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  logic [DATA_W-1:0]   prod_r, prod_nxt;
  logic                pend_hi_r;
  logic [SIZE_W-1:0]   matrix_size_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic                accept, load_ok;
  logic [IDX_W:0]      size_eff;
  logic [ADDR_W-1:0]   load_addr;
  logic [DATA_W-1:0]   qa, qb, qc;
  logic [HALF_W-1:0]   a_half, b_half;
  logic                we_a, we_b, we_c;
  logic [ADDR_W-1:0]   waddr_c;
  logic [DATA_W-1:0]   wdata_c;
  logic                cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MATRIX_SIZE);
  assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? CFG_DATA_W'(matrix_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_size_r <= SIZE_RESET;
    end else if (cfg_wr) begin
      matrix_size_r <= pwdata[SIZE_W-1:0];
    end
  end

  // Clamp size in use to 1..MAX_DIM
  always_comb begin
    if (matrix_size_r == '0) begin
      size_eff = (IDX_W+1)'(1);
    end else if (32'(matrix_size_r) > 32'(MAX_DIM)) begin
      size_eff = (IDX_W+1)'(MAX_DIM);
    end else begin
      size_eff = (IDX_W+1)'(matrix_size_r);
    end
  end

  assign n_last_nxt = IDX_W'(size_eff - (IDX_W+1)'(1));

  // Accept items; loads write the stores directly
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign load_ok   = (32'(in_data.row) < 32'(MAX_DIM)) && (32'(in_data.col) < 32'(MAX_DIM));
  assign load_addr = addr_of(32'(in_data.row), 32'(in_data.col));

  assign we_a    = accept && load_ok && (in_data.cmd == CMD_LOAD_A);
  assign we_b    = accept && load_ok && (in_data.cmd == CMD_LOAD_B);
  assign we_c    = (accept && load_ok && (in_data.cmd == CMD_LOAD_C)) || (state_r == S_EMIT);
  assign waddr_c = (state_r == S_EMIT) ? addr_of(32'(i_r), 32'(j_r)) : load_addr;
  assign wdata_c = (state_r == S_EMIT) ? acc_r : in_data.value;

  mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (load_addr),
    .wdata (in_data.value),
    .raddr (addr_of(32'(i_r), 32'(k_r))),
    .rdata (qa)
  );

  mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (load_addr),
    .wdata (in_data.value),
    .raddr (addr_of(32'(k_r), 32'(j_r))),
    .rdata (qb)
  );

  mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store_c (
    .clk   (clk),
    .we    (we_c),
    .waddr (waddr_c),
    .wdata (wdata_c),
    .raddr (addr_of(32'(i_r), 32'(j_r))),
    .rdata (qc)
  );

  // Shared multiplier: low*low, low*high, high*low halves in turn
  assign a_half   = (state_r == S_M2) ? qa[DATA_W-1:HALF_W] : qa[HALF_W-1:0];
  assign b_half   = (state_r == S_M1) ? qb[DATA_W-1:HALF_W] : qb[HALF_W-1:0];
  assign prod_nxt = a_half * b_half;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Accumulate: seed from C, add low product, then cross products shifted up
  always_comb begin
    if ((state_r == S_M0) && (k_r == '0)) begin
      acc_nxt = qc;
    end else if (state_r == S_M1) begin
      acc_nxt = acc_r + prod_r;
    end else if ((state_r == S_M2) || pend_hi_r) begin
      acc_nxt = acc_r + {prod_r[HALF_W-1:0], {HALF_W{1'b0}}};
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Sequencer over elements (i,j) and product steps k
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_data.cmd == CMD_COMPUTE)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_M0;
      S_M0:    state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2: begin
        if (k_r == n_last_r) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = S_FETCH;
        end
      end
      S_FIN:   state_nxt = S_EMIT;
      S_EMIT: begin
        k_nxt = '0;
        if (j_r == n_last_r) begin
          j_nxt = '0;
          if (i_r == n_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_FETCH;
          end
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = S_FETCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pend_hi_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pend_hi_r <= (state_r == S_M2);
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    if (accept) begin
      n_last_r <= n_last_nxt;
    end
  end

  // Register the result item for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT) begin
      out_data_r.out_row   <= IDX_FLD_W'(i_r);
      out_data_r.out_col   <= IDX_FLD_W'(j_r);
      out_data_r.out_value <= acc_r;
      out_data_r.last      <= (i_r == n_last_r) && (j_r == n_last_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_out_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EMIT))
    else $error("result strobe without an emit cycle");

  a_last_ends_compute: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last) |-> (state_r == S_IDLE))
    else $error("sequencer still busy after the last element");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ((k_r <= n_last_r) && (i_r <= n_last_r) && (j_r <= n_last_r)))
    else $error("loop index beyond size in use");

  a_pending_add: assert property (@(posedge clk) disable iff (!rst_n)
    pend_hi_r |-> ((state_r == S_FETCH) || (state_r == S_FIN)))
    else $error("pending cross product dropped");

endmodule

FILE: sv/mma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, read one word every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: test/matrix_multiply_accumulate_tb.sv
// Self-checking testbench for the matrix multiply-accumulate block: load, compute and APB traffic.
module matrix_multiply_accumulate_tb;
  import mma_pkg::*;

  localparam int DIM         = MAX_DIM_DEF;
  localparam int DEPTH       = DIM * DIM;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int PHASE_ITEMS = 25;

  // Byte addresses of the mapped register and of an unmapped word
  localparam logic [CFG_ADDR_W-1:0] ADDR_SIZE     = {REG_MATRIX_SIZE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = {~REG_MATRIX_SIZE, 2'b00};

  localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // Predicts the updated C elements and holds them until they come out
  class mac_scoreboard;
    logic [DATA_W-1:0] mat_a [DEPTH];
    logic [DATA_W-1:0] mat_b [DEPTH];
    logic [DATA_W-1:0] mat_c [DEPTH];
    bit                wr_a  [DEPTH];
    bit                wr_b  [DEPTH];
    bit                wr_c  [DEPTH];
    logic [SIZE_W-1:0] size_reg;
    out_item_t         elem_q [$];
    int                errors;

    function new();
      size_reg = SIZE_RESET;
      errors   = 0;
      foreach (mat_a[i]) begin
        mat_a[i] = '0;
        mat_b[i] = '0;
        mat_c[i] = '0;
        wr_a[i]  = 1'b0;
        wr_b[i]  = 1'b0;
        wr_c[i]  = 1'b0;
      end
    endfunction

    // Size in use: zero acts as one, anything above the built maximum saturates
    function int dim();
      if (size_reg == '0) return 1;
      if (size_reg > DIM) return DIM;
      return int'(size_reg);
    endfunction

    function bit written(cmd_t cmd, int addr);
      case (cmd)
        CMD_LOAD_A: return wr_a[addr];
        CMD_LOAD_B: return wr_b[addr];
        default:    return wr_c[addr];
      endcase
    endfunction

    // Writes to any register other than matrix_size are dropped
    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr[CFG_ADDR_W-1] == REG_MATRIX_SIZE) size_reg = data[SIZE_W-1:0];
    endfunction

    function void note_item(in_item_t it);
      int                n;
      int                addr;
      logic [DATA_W-1:0] acc;
      out_item_t         e;
      addr = int'(it.row) * DIM + int'(it.col);
      case (it.cmd)
        CMD_LOAD_A: begin
          mat_a[addr] = it.value;
          wr_a[addr]  = 1'b1;
        end
        CMD_LOAD_B: begin
          mat_b[addr] = it.value;
          wr_b[addr]  = 1'b1;
        end
        CMD_LOAD_C: begin
          mat_c[addr] = it.value;
          wr_c[addr]  = 1'b1;
        end
        CMD_COMPUTE: begin
          // Accumulate into C in row-major order, wrapping at 64 bits
          n = dim();
          for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
              acc = mat_c[i*DIM + j];
              for (int k = 0; k < n; k++) begin
                acc = acc + mat_a[i*DIM + k] * mat_b[k*DIM + j];
              end
              mat_c[i*DIM + j] = acc;
              e.out_row   = i[IDX_FLD_W-1:0];
              e.out_col   = j[IDX_FLD_W-1:0];
              e.out_value = acc;
              e.last      = (i == n - 1) && (j == n - 1);
              elem_q.push_back(e);
            end
          end
        end
      endcase
    endfunction

    function void check_elem(out_item_t got);
      out_item_t exp_e;
      if (elem_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected element: expected none, actual row %0d col %0d",
                 $time, got.out_row, got.out_col);
        $display("%0t: unexpected element: actual value %0d last %0b",
                 $time, got.out_value, got.last);
        return;
      end
      exp_e = elem_q.pop_front();
      if (got.out_row !== exp_e.out_row) begin
        errors++;
        $display("%0t: out_row expected %0d actual %0d", $time, exp_e.out_row, got.out_row);
      end
      if (got.out_col !== exp_e.out_col) begin
        errors++;
        $display("%0t: out_col expected %0d actual %0d", $time, exp_e.out_col, got.out_col);
      end
      if (got.out_value !== exp_e.out_value) begin
        errors++;
        $display("%0t: out_value (%0d,%0d) expected %0d actual %0d", $time,
                 exp_e.out_row, exp_e.out_col, exp_e.out_value, got.out_value);
      end
      if (got.last !== exp_e.last) begin
        errors++;
        $display("%0t: last (%0d,%0d) expected %0b actual %0b", $time,
                 exp_e.out_row, exp_e.out_col, exp_e.last, got.last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_data;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mac_scoreboard sb = new();
  int unsigned   cycle_count = 0;
  int            items_sent = 0;
  int            idle_pct = 0;
  bit            idle_on = 1'b0;
  cmd_t          load_cmds [3] = '{CMD_LOAD_A, CMD_LOAD_B, CMD_LOAD_C};
  int            phase_sizes [13] = '{3, 1, 2, 9, 4, 15, 5, 2, 6, 8, 3, 7, 1};
  int            idle_by_mode [3] = '{0, 59, 23};
  int            n;
  int            phase_start;
  int            nloads;

  matrix_multiply_accumulate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // Check every strobed element against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_elem(out_data);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      4:       return DATA_W'($urandom_range(1, 15));
      5:       return -DATA_W'($urandom_range(1, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Present one item, optionally after a gap, and hold it until accepted
  task automatic send_item(in_item_t it);
    if (idle_on && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_data <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_load(cmd_t cmd, int r, int c, logic [DATA_W-1:0] v);
    in_item_t it;
    it.cmd   = cmd;
    it.row   = r[IDX_FLD_W-1:0];
    it.col   = c[IDX_FLD_W-1:0];
    it.value = v;
    send_item(it);
  endtask

  // Compute ignores the index and value fields, so randomize them
  task automatic send_compute();
    in_item_t it;
    it.cmd   = CMD_COMPUTE;
    it.row   = IDX_FLD_W'($urandom_range(0, DIM - 1));
    it.col   = IDX_FLD_W'($urandom_range(0, DIM - 1));
    it.value = {$urandom, $urandom};
    send_item(it);
  endtask

  // Mostly inside the size in use, sometimes anywhere in the store
  task automatic send_random_load(int dim_n);
    int r;
    int c;
    if ($urandom_range(0, 4) == 0) begin
      r = $urandom_range(0, DIM - 1);
      c = $urandom_range(0, DIM - 1);
    end else begin
      r = $urandom_range(0, dim_n - 1);
      c = $urandom_range(0, dim_n - 1);
    end
    send_load(load_cmds[$urandom_range(0, 2)], r, c, pick_value());
  endtask

  // Load every element a compute at this size would read but never got written
  task automatic fill_unwritten(int dim_n);
    foreach (load_cmds[s]) begin
      for (int r = 0; r < dim_n; r++) begin
        for (int c = 0; c < dim_n; c++) begin
          if (!sb.written(load_cmds[s], r*DIM + c)) send_load(load_cmds[s], r, c, pick_value());
        end
      end
    end
  endtask

  // Drop start and let the block drain before touching configuration
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.elem_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_check_size();
    logic [CFG_DATA_W-1:0] rd;
    logic [CFG_DATA_W-1:0] exp_rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_SIZE;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd     = prdata;
    exp_rd = CFG_DATA_W'(sb.size_reg);
    if (rd !== exp_rd) begin
      sb.errors++;
      $display("%0t: matrix_size read expected %0d actual %0d", $time, exp_rd, rd);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits are random; only the low nibble lands in the register
  task automatic set_size(int size_val);
    logic [CFG_DATA_W-1:0] d;
    d = $urandom;
    d[SIZE_W-1:0] = size_val[SIZE_W-1:0];
    cfg_write(ADDR_SIZE, d);
    cfg_check_size();
  endtask

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset value, then an unmapped write that must leave it alone
    cfg_check_size();
    cfg_write(ADDR_UNMAPPED, 32'd3);
    cfg_check_size();

    // Size zero behaves as one; overflowing products and repeated accumulation
    set_size(0);
    send_load(CMD_LOAD_A, 0, 0, VAL_MAX);
    send_load(CMD_LOAD_B, 0, 0, VAL_MAX);
    send_load(CMD_LOAD_C, 0, 0, VAL_MIN);
    send_compute();
    send_compute();
    // Loads outside the size in use still land in the stores
    send_load(CMD_LOAD_A, 7, 7, '1);
    send_load(CMD_LOAD_B, 7, 7, VAL_MIN);
    send_load(CMD_LOAD_C, 7, 7, VAL_MAX);
    send_load(CMD_LOAD_B, 0, 0, '1);
    send_load(CMD_LOAD_A, 0, 0, VAL_MIN);
    send_compute();
    set_size(2);
    fill_unwritten(2);
    send_compute();

    // Random phases over several sizes and idle mixes
    foreach (phase_sizes[p]) begin
      set_size(phase_sizes[p]);
      n           = sb.dim();
      idle_pct    = idle_by_mode[p % 3];
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        idle_on = ($urandom_range(0, 3) != 0);
        nloads  = $urandom_range(1, (n*n + 1 < 12) ? n*n + 1 : 12);
        repeat (nloads) send_random_load(n);
        fill_unwritten(n);
        send_compute();
        if ($urandom_range(0, 9) < 3) send_compute();
      end
    end

    // Drain and finish
    start <= 1'b0;
    while (sb.elem_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
